@@ src/xtea_pkg.sv @@
// ----------------------------------------------------------------------------
// xtea_pkg
// shared types, constants and the round mixing function for the xtea cipher
// ----------------------------------------------------------------------------
`default_nettype none

package xtea_pkg;

    localparam int unsigned ROUNDS_DEF = 32;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned KEY_WORDS  = 4;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned KEY_HI_LSB = 11;

    localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_KEY_0 = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_1 = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_2 = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_3 = 8'd3;

    localparam logic [KEY_WORDS-1:0][WORD_W-1:0] KEY_RESET = {
        32'h16DB_7FC2, 32'h3A17_0B92, 32'h0382_7D0F, 32'h6C0A_5452
    };

    typedef logic [KEY_WORDS-1:0][WORD_W-1:0] t_key;

    typedef struct packed {
        logic              func;
        logic [WORD_W-1:0] word_first;
        logic [WORD_W-1:0] word_second;
    } t_xtea_in;

    typedef struct packed {
        logic [WORD_W-1:0] out_first;
        logic [WORD_W-1:0] out_second;
    } t_xtea_out;

    // word carried from cell to cell
    typedef struct packed {
        logic              func;
        logic [WORD_W-1:0] v0;
        logic [WORD_W-1:0] v1;
    } t_cell_data;

    function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] v);
        return ((v << 4) ^ (v >> 5)) + v;
    endfunction

endpackage

`default_nettype wire

@@ src/xtea_cell.sv @@
// ----------------------------------------------------------------------------
// xtea_cell
// one half round: updates one word of the block from the other, registered
// ----------------------------------------------------------------------------
`default_nettype none

module xtea_cell #(
    parameter int unsigned ROUNDS   = xtea_pkg::ROUNDS_DEF,
    parameter int unsigned HALF_IDX = 0
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire xtea_pkg::t_key       i_key,
    input  wire logic                 i_valid,
    input  wire xtea_pkg::t_cell_data i_data,
    output logic                      o_valid,
    output xtea_pkg::t_cell_data      o_data
);

    localparam int unsigned HI = xtea_pkg::KEY_HI_LSB;
    localparam bit IS_ODD = (HALF_IDX % 2) == 1;

    // round sums are fixed per cell, one for each direction
    localparam int unsigned ENC_MULT = HALF_IDX / 2 + HALF_IDX % 2;
    localparam int unsigned DEC_MULT = ROUNDS - HALF_IDX / 2 - HALF_IDX % 2;
    localparam logic [63:0] ENC_PROD = 64'(ENC_MULT) * 64'(xtea_pkg::DELTA);
    localparam logic [63:0] DEC_PROD = 64'(DEC_MULT) * 64'(xtea_pkg::DELTA);
    localparam logic [xtea_pkg::WORD_W-1:0] ENC_SUM = ENC_PROD[xtea_pkg::WORD_W-1:0];
    localparam logic [xtea_pkg::WORD_W-1:0] DEC_SUM = DEC_PROD[xtea_pkg::WORD_W-1:0];

    // low sum bits pick the key when the first word is updated, bits 12:11 otherwise
    localparam logic [1:0] ENC_KIDX = IS_ODD ? ENC_SUM[HI+1:HI] : ENC_SUM[1:0];
    localparam logic [1:0] DEC_KIDX = IS_ODD ? DEC_SUM[1:0]     : DEC_SUM[HI+1:HI];

    logic                            r_valid;
    xtea_pkg::t_cell_data            r_data;
    xtea_pkg::t_cell_data            n_data;
    logic                            upd_first;
    logic [xtea_pkg::WORD_W-1:0]     src;
    logic [xtea_pkg::WORD_W-1:0]     dst;
    logic [xtea_pkg::WORD_W-1:0]     term;
    logic [xtea_pkg::WORD_W-1:0]     f;
    logic [xtea_pkg::WORD_W-1:0]     upd;

    always_comb begin
        // encrypt updates the first word in even cells, decrypt in odd cells
        upd_first = IS_ODD ? i_data.func : ~i_data.func;
        src       = upd_first ? i_data.v1 : i_data.v0;
        dst       = upd_first ? i_data.v0 : i_data.v1;
        term      = i_data.func ? (DEC_SUM + i_key[DEC_KIDX])
                                : (ENC_SUM + i_key[ENC_KIDX]);
        f         = xtea_pkg::mix(src) ^ term;
        upd       = i_data.func ? (dst - f) : (dst + f);
        n_data      = i_data;
        n_data.v0   = upd_first ? upd : i_data.v0;
        n_data.v1   = upd_first ? i_data.v1 : upd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

@@ src/xtea_block_cipher.sv @@
// ----------------------------------------------------------------------------
// xtea_block_cipher
// xtea 64-bit block cipher, 128-bit key, built as a chain of half-round cells
// ----------------------------------------------------------------------------
//  channel   signals                              direction
//  input     i_valid, o_stall, i_data             word in (func, first, second)
//  output    o_valid, i_stall, o_data             word out (first, second)
//  config    i_cfg_valid, o_cfg_ready,            key word write, index 0..3
//            i_cfg_index, i_cfg_data
//
//  one word enters per cycle unless a finished word is stalled at the output;
//  every half-round cell of the chain registers its word
//  a stall on a waiting result freezes the whole chain; a one-word skid register
//  at the input still takes the next word while the result waits
//  reset (synchronous, active low) empties the chain and loads the key
//  words with their default values; the config port is always ready
// ----------------------------------------------------------------------------
`default_nettype none

module xtea_block_cipher #(
    parameter int unsigned ROUNDS = xtea_pkg::ROUNDS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire xtea_pkg::t_xtea_in                i_data,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output xtea_pkg::t_xtea_out                    o_data,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [xtea_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [xtea_pkg::WORD_W-1:0]       i_cfg_data
);

    localparam int unsigned CELLS = 2 * ROUNDS;

    xtea_pkg::t_key        r_key;
    logic                  r_skid_valid;
    xtea_pkg::t_xtea_in    r_skid;
    logic                  w_en;
    logic                  w_in_acc;
    xtea_pkg::t_xtea_in    w_src;
    logic [CELLS:0]        w_valid;
    xtea_pkg::t_cell_data  w_data [CELLS+1];

    // key words
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= xtea_pkg::KEY_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                xtea_pkg::REG_KEY_0: r_key[0] <= i_cfg_data;
                xtea_pkg::REG_KEY_1: r_key[1] <= i_cfg_data;
                xtea_pkg::REG_KEY_2: r_key[2] <= i_cfg_data;
                xtea_pkg::REG_KEY_3: r_key[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // chain advances unless a finished word is held at the output
    assign w_en     = !(w_valid[CELLS] && i_stall);
    assign o_stall  = r_skid_valid;
    assign w_in_acc = i_valid && !o_stall;
    assign w_src    = r_skid_valid ? r_skid : i_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (w_en) begin
            r_skid_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && !w_en) begin
            r_skid <= i_data;
        end
    end

    assign w_valid[0]     = r_skid_valid || w_in_acc;
    assign w_data[0].func = w_src.func;
    assign w_data[0].v0   = w_src.word_first;
    assign w_data[0].v1   = w_src.word_second;

    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        xtea_cell #(
            .ROUNDS   (ROUNDS),
            .HALF_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_key   (r_key),
            .i_valid (w_valid[g]),
            .i_data  (w_data[g]),
            .o_valid (w_valid[g+1]),
            .o_data  (w_data[g+1])
        );
    end

    assign o_valid           = w_valid[CELLS];
    assign o_data.out_first  = w_data[CELLS].v0;
    assign o_data.out_second = w_data[CELLS].v1;

    // a word taken while the chain is frozen must wait in the skid register
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !w_en) |=> o_stall)
        else $error("input word accepted during stall was not held");

    // the skid register drains as soon as the chain moves
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && w_en) |=> !r_skid_valid)
        else $error("skid register not drained when chain advanced");

    // a frozen chain keeps its occupancy
    a_chain_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> (w_valid[CELLS:1] == $past(w_valid[CELLS:1])))
        else $error("cell chain occupancy changed while frozen");

endmodule

`default_nettype wire

@@ tb/xtea_block_cipher_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtea_block_cipher_tb
// self-checking bench for the xtea block cipher: a table of directed blocks
// under fixed keys, then random blocks and round trips under changing keys,
// each result compared with a known answer or a cycle-free model of the cipher
// ----------------------------------------------------------------------------

module xtea_block_cipher_tb;

    localparam int unsigned CIPHER_ROUNDS    = xtea_pkg::ROUNDS_DEF;
    localparam int          WATCHDOG_LIMIT   = 2000;
    localparam int          TAIL_CYCLES      = 2 * CIPHER_ROUNDS + 16;
    localparam int          NUM_VECTORS      = 17;
    localparam int          RANDOM_PHASES    = 6;
    localparam int          RANDOM_PER_PHASE = 322;
    localparam int          MAX_REPORTS      = 50;

    localparam logic FUNC_ENCRYPT = 1'b0;
    localparam logic FUNC_DECRYPT = 1'b1;

    localparam xtea_pkg::t_key COUNT_KEY = {
        32'h0C0D_0E0F, 32'h0809_0A0B, 32'h0405_0607, 32'h0001_0203
    };

    typedef enum logic [1:0] {KEYS_RESET, KEYS_ZERO, KEYS_COUNT, KEYS_ONES} t_key_set;

    typedef struct packed {
        t_key_set                    keys;
        logic                        func;
        logic [xtea_pkg::WORD_W-1:0] first;
        logic [xtea_pkg::WORD_W-1:0] second;
        logic                        known;
        logic [xtea_pkg::WORD_W-1:0] want_first;
        logic [xtea_pkg::WORD_W-1:0] want_second;
    } t_vector_row;

    logic                                 i_clk       = 1'b0;
    logic                                 i_rst_n     = 1'b0;
    logic                                 i_valid     = 1'b0;
    logic                                 o_stall;
    xtea_pkg::t_xtea_in                   i_data      = '0;
    logic                                 o_valid;
    logic                                 i_stall     = 1'b0;
    xtea_pkg::t_xtea_out                  o_data;
    logic                                 i_cfg_valid = 1'b0;
    logic                                 o_cfg_ready;
    logic [xtea_pkg::CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [xtea_pkg::WORD_W-1:0]          i_cfg_data  = '0;

    logic [xtea_pkg::WORD_W-1:0]          key_shadow [xtea_pkg::KEY_WORDS];
    xtea_pkg::t_xtea_out                  blocks_pending [$];
    xtea_pkg::t_xtea_out                  got_block;
    xtea_pkg::t_xtea_out                  want_block;
    xtea_pkg::t_xtea_in                   last_block  = '0;
    xtea_pkg::t_xtea_out                  last_result = '0;
    int                     mismatch_count = 0;
    int                     idle_cycles    = 0;
    int                     gap_pct        = 0;
    int                     stall_pct      = 0;
    int                     gap_table   [RANDOM_PHASES] = '{25, 10, 40, 0, 20, 0};
    int                     stall_table [RANDOM_PHASES] = '{25, 40, 10, 0, 30, 0};

    // known answers: zero key / zero block, and the counting key on "ABCDEFGH"
    t_vector_row vectors [NUM_VECTORS] = '{
        '{KEYS_RESET, FUNC_ENCRYPT, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
        '{KEYS_RESET, FUNC_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0},
        '{KEYS_RESET, FUNC_DECRYPT, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
        '{KEYS_RESET, FUNC_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0},
        '{KEYS_RESET, FUNC_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0},
        '{KEYS_RESET, FUNC_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
        '{KEYS_RESET, FUNC_ENCRYPT, 32'h8000_0000, 32'h0000_0001, 1'b0, 32'h0, 32'h0},
        '{KEYS_RESET, FUNC_DECRYPT, 32'h0000_0001, 32'h8000_0000, 1'b0, 32'h0, 32'h0},
        '{KEYS_RESET, FUNC_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 32'h0, 32'h0},
        '{KEYS_RESET, FUNC_DECRYPT, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'h0, 32'h0},
        '{KEYS_ZERO,  FUNC_ENCRYPT, 32'h0000_0000, 32'h0000_0000,
          1'b1, 32'hDEE9_D4D8, 32'hF713_1ED9},
        '{KEYS_ZERO,  FUNC_DECRYPT, 32'hDEE9_D4D8, 32'hF713_1ED9,
          1'b1, 32'h0000_0000, 32'h0000_0000},
        '{KEYS_ZERO,  FUNC_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0},
        '{KEYS_COUNT, FUNC_ENCRYPT, 32'h4142_4344, 32'h4546_4748,
          1'b1, 32'h497D_F3D0, 32'h7261_2CB5},
        '{KEYS_COUNT, FUNC_DECRYPT, 32'h497D_F3D0, 32'h7261_2CB5,
          1'b1, 32'h4142_4344, 32'h4546_4748},
        '{KEYS_ONES,  FUNC_ENCRYPT, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
        '{KEYS_ONES,  FUNC_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0}
    };

    xtea_block_cipher #(
        .ROUNDS      (CIPHER_ROUNDS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // full 32-round cipher on the shadow key
    function automatic xtea_pkg::t_xtea_out xtea_predict(input xtea_pkg::t_xtea_in blk);
        logic [xtea_pkg::WORD_W-1:0] v0;
        logic [xtea_pkg::WORD_W-1:0] v1;
        logic [xtea_pkg::WORD_W-1:0] sum;
        logic [xtea_pkg::WORD_W-1:0] m;
        xtea_pkg::t_xtea_out         res;
        v0 = blk.word_first;
        v1 = blk.word_second;
        if (blk.func == FUNC_DECRYPT) begin
            sum = xtea_pkg::DELTA * CIPHER_ROUNDS;
            for (int r = 0; r < CIPHER_ROUNDS; r++) begin
                m   = ((v0 << 4) ^ (v0 >> 5)) + v0;
                v1  = v1 - (m ^ (sum + key_shadow[sum[xtea_pkg::KEY_HI_LSB+1:
                                                      xtea_pkg::KEY_HI_LSB]]));
                sum = sum - xtea_pkg::DELTA;
                m   = ((v1 << 4) ^ (v1 >> 5)) + v1;
                v0  = v0 - (m ^ (sum + key_shadow[sum[1:0]]));
            end
        end else begin
            sum = '0;
            for (int r = 0; r < CIPHER_ROUNDS; r++) begin
                m   = ((v1 << 4) ^ (v1 >> 5)) + v1;
                v0  = v0 + (m ^ (sum + key_shadow[sum[1:0]]));
                sum = sum + xtea_pkg::DELTA;
                m   = ((v0 << 4) ^ (v0 >> 5)) + v0;
                v1  = v1 + (m ^ (sum + key_shadow[sum[xtea_pkg::KEY_HI_LSB+1:
                                                      xtea_pkg::KEY_HI_LSB]]));
            end
        end
        res.out_first  = v0;
        res.out_second = v1;
        return res;
    endfunction

    function automatic logic [xtea_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [xtea_pkg::WORD_W-1:0] got,
                                   input logic [xtea_pkg::WORD_W-1:0] want);
        if (mismatch_count < MAX_REPORTS)
            $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // leaves i_cfg_valid high so back-to-back writes do not toggle it
    task automatic write_reg(input logic [xtea_pkg::CFG_IDX_W-1:0] idx,
                             input logic [xtea_pkg::WORD_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx <= xtea_pkg::REG_KEY_3)
            key_shadow[idx[1:0]] = val;
    endtask

    task automatic program_key(input xtea_pkg::t_key words, input bit with_stray);
        for (int k = 0; k < xtea_pkg::KEY_WORDS; k++)
            write_reg(xtea_pkg::REG_KEY_0 + k[xtea_pkg::CFG_IDX_W-1:0], words[k]);
        // index past the key words must leave the key alone
        if (with_stray)
            write_reg(xtea_pkg::REG_KEY_3 + 8'd1 + 8'($urandom_range(0, 251)), $urandom);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_block(input xtea_pkg::t_xtea_in blk, input logic known,
                              input xtea_pkg::t_xtea_out given);
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= blk;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        last_block  = blk;
        last_result = known ? given : xtea_predict(blk);
        blocks_pending.push_back(last_result);
    endtask

    // always waits on the clock before it returns, so valid is never dropped and raised in one step
    task automatic drain_pipeline();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (blocks_pending.size() != 0);
    endtask

    // output side backpressure in bursts
    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got_block = o_data;
            if (blocks_pending.size() == 0) begin
                report_mismatch("unexpected word, out_first", got_block.out_first, 'x);
            end else begin
                want_block = blocks_pending.pop_front();
                if (got_block.out_first !== want_block.out_first)
                    report_mismatch("out_first", got_block.out_first, want_block.out_first);
                if (got_block.out_second !== want_block.out_second)
                    report_mismatch("out_second", got_block.out_second, want_block.out_second);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        xtea_pkg::t_key      new_key;
        xtea_pkg::t_xtea_in  blk;
        xtea_pkg::t_xtea_out given;
        t_key_set            key_now;

        for (int k = 0; k < xtea_pkg::KEY_WORDS; k++)
            key_shadow[k] = xtea_pkg::KEY_RESET[k];
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        gap_pct   = 20;
        stall_pct = 20;

        // directed table, reset key first so the reset values are checked
        key_now = KEYS_RESET;
        for (int n = 0; n < NUM_VECTORS; n++) begin
            if (vectors[n].keys != key_now) begin
                drain_pipeline();
                key_now = vectors[n].keys;
                unique case (key_now)
                    KEYS_ZERO:  new_key = '0;
                    KEYS_ONES:  new_key = '1;
                    KEYS_COUNT: new_key = COUNT_KEY;
                    KEYS_RESET: new_key = xtea_pkg::KEY_RESET;
                endcase
                program_key(new_key, 1'b0);
            end
            blk.func        = vectors[n].func;
            blk.word_first  = vectors[n].first;
            blk.word_second = vectors[n].second;
            given.out_first  = vectors[n].want_first;
            given.out_second = vectors[n].want_second;
            send_block(blk, vectors[n].known, given);
        end

        // random blocks, a key written per phase (the reset key in the second); the last phase runs without idling
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain_pipeline();
            for (int k = 0; k < xtea_pkg::KEY_WORDS; k++)
                new_key[k] = pick_word();
            if (p == 1)
                new_key = xtea_pkg::KEY_RESET;
            program_key(new_key, 1'b1);
            gap_pct   = gap_table[p];
            stall_pct = stall_table[p];
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (p == 2 && n == RANDOM_PER_PHASE / 2)
                    drain_pipeline();
                if (n > 0 && $urandom_range(0, 3) == 0) begin
                    // feed the last result back the other way
                    blk.func        = (last_block.func == FUNC_ENCRYPT) ? FUNC_DECRYPT
                                                                        : FUNC_ENCRYPT;
                    blk.word_first  = last_result.out_first;
                    blk.word_second = last_result.out_second;
                end else begin
                    blk.func        = $urandom_range(0, 1) ? FUNC_DECRYPT : FUNC_ENCRYPT;
                    blk.word_first  = pick_word();
                    blk.word_second = pick_word();
                end
                send_block(blk, 1'b0, '0);
            end
        end

        drain_pipeline();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (blocks_pending.size() != 0)
            report_mismatch("words never returned, count", blocks_pending.size(), '0);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ files.f @@
src/xtea_pkg.sv
src/xtea_cell.sv
src/xtea_block_cipher.sv
tb/xtea_block_cipher_tb.sv
